// File: design/dmpc_pkg.sv
// Package for the DC motor position controller: operation and register codes,
// field widths, reset values and the shared flag bundle. No dependencies.
package dmpc_pkg;

    localparam int DMPC_POSITION_BITS = 11;
    localparam int DMPC_TIME_BITS     = 32;

    localparam int OPERATION_W = 3;
    localparam int TARGET_W    = 11;
    localparam int ENCODER_W   = 2;
    localparam int LIMIT_W     = 10;
    localparam int TIMEOUT_W   = 16;
    localparam int CFG_DATA_W  = 16;
    localparam int CFG_INDEX_W = 1;

    localparam logic [LIMIT_W-1:0]   LIMIT_RESET   = 10'd100;
    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 16'd1000;

    localparam logic [ENCODER_W-1:0] ENC_NONE = 2'd0;

    typedef enum logic [OPERATION_W-1:0] {
        OP_TICK        = 3'd0,
        OP_MOVE        = 3'd1,
        OP_HOME        = 3'd2,
        OP_PAUSE       = 3'd3,
        OP_STOP        = 3'd4,
        OP_RETURN_ZERO = 3'd5
    } op_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_POSITION_LIMIT = 1'b0,
        CFG_STALL_TIMEOUT  = 1'b1
    } cfg_idx_t;

    typedef struct packed {
        logic line_plus;
        logic line_minus;
        logic active;
        logic forward;
        logic reached;
        logic blocked;
        logic homing;
    } flags_t;

endpackage

// File: design/dmpc_if.sv
// Request and result channel interfaces of the motor position controller.
// Depends on dmpc_pkg for the field widths.
interface dmpc_in_if;
    import dmpc_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [OPERATION_W-1:0] operation;
    logic [TARGET_W-1:0]    target;
    logic [ENCODER_W-1:0]   encoder_event;
    logic                   end_switch;

    modport source (output valid, output operation, output target,
                    output encoder_event, output end_switch, input ready);
    modport sink   (input valid, input operation, input target,
                    input encoder_event, input end_switch, output ready);
endinterface

interface dmpc_out_if #(
    parameter int POSITION_BITS = dmpc_pkg::DMPC_POSITION_BITS
);
    logic                     valid;
    logic                     ready;
    logic                     drive_plus;
    logic                     drive_minus;
    logic [POSITION_BITS-1:0] position;
    logic                     target_reached;
    logic                     blocked;
    logic                     moving;
    logic                     homing;

    modport source (output valid, output drive_plus, output drive_minus,
                    output position, output target_reached, output blocked,
                    output moving, output homing, input ready);
    modport sink   (input valid, input drive_plus, input drive_minus,
                    input position, input target_reached, input blocked,
                    input moving, input homing, output ready);
endinterface

// File: design/dmpc_step.sv
// Next-state logic of the axis: applies one request to the current state.
// Purely combinational; depends on dmpc_pkg.
module dmpc_step #(
    parameter int POSITION_BITS = dmpc_pkg::DMPC_POSITION_BITS,
    parameter int TIME_BITS     = dmpc_pkg::DMPC_TIME_BITS
) (
    input  logic [dmpc_pkg::OPERATION_W-1:0] operation,
    input  logic [dmpc_pkg::TARGET_W-1:0]    target,
    input  logic [dmpc_pkg::ENCODER_W-1:0]   encoder_event,
    input  logic                             end_switch,
    input  logic [dmpc_pkg::LIMIT_W-1:0]     position_limit,
    input  logic [dmpc_pkg::TIMEOUT_W-1:0]   stall_timeout_ms,
    input  logic signed [POSITION_BITS-1:0]  pos,
    input  logic [dmpc_pkg::LIMIT_W-1:0]     goal,
    input  logic signed [POSITION_BITS-1:0]  prev_pos,
    input  logic [dmpc_pkg::ENCODER_W-1:0]   prev_enc,
    input  logic [TIME_BITS-1:0]             ms_time,
    input  logic [TIME_BITS-1:0]             last_move,
    input  dmpc_pkg::flags_t                 flags,
    output logic signed [POSITION_BITS-1:0]  pos_next,
    output logic [dmpc_pkg::LIMIT_W-1:0]     goal_next,
    output logic signed [POSITION_BITS-1:0]  prev_pos_next,
    output logic [dmpc_pkg::ENCODER_W-1:0]   prev_enc_next,
    output logic [TIME_BITS-1:0]             ms_time_next,
    output logic [TIME_BITS-1:0]             last_move_next,
    output dmpc_pkg::flags_t                 flags_next
);
    import dmpc_pkg::*;

    // Compare width that holds both the position and any 10-bit limit value.
    localparam int CW = ((POSITION_BITS > TARGET_W) ? POSITION_BITS : TARGET_W) + 1;

    localparam logic signed [POSITION_BITS-1:0] POS_MAX =
        {1'b0, {(POSITION_BITS-1){1'b1}}};
    localparam logic signed [POSITION_BITS-1:0] POS_MIN =
        {1'b1, {(POSITION_BITS-1){1'b0}}};

    op_t                       op;
    logic signed [CW-1:0]      pos_x;
    logic signed [CW-1:0]      goal_x;
    logic signed [CW-1:0]      limit_x;
    logic signed [CW-1:0]      target_x;
    logic signed [CW-1:0]      want_x;
    logic [LIMIT_W-1:0]        clamped;
    logic [LIMIT_W-1:0]        want;
    logic                      do_move;
    logic [TIME_BITS-1:0]      tick_time;
    logic signed [POSITION_BITS-1:0] pos_sw;
    logic signed [POSITION_BITS-1:0] pos_cnt;
    logic                      enc_step;
    logic [TIME_BITS-1:0]      last_tick;
    logic [TIME_BITS-1:0]      elapsed;
    logic                      stalled;
    flags_t                    f_drive;

    assign op       = op_t'(operation);
    assign pos_x    = CW'(pos);
    assign goal_x   = signed'({{(CW-LIMIT_W){1'b0}}, goal});
    assign limit_x  = signed'({{(CW-LIMIT_W){1'b0}}, position_limit});
    assign target_x = CW'(signed'(target));

    // Move target clamped to 0..limit.
    always_comb
    begin
        if (target_x < 0)
            clamped = '0;
        else if (target_x > limit_x)
            clamped = position_limit;
        else
            clamped = target[LIMIT_W-1:0];
    end

    assign want    = (op == OP_MOVE) ? clamped : '0;
    assign want_x  = signed'({{(CW-LIMIT_W){1'b0}}, want});
    assign do_move = (op == OP_MOVE) || ((op == OP_RETURN_ZERO) && (pos != '0));

    // Tick path: drive decision on the old position, then end switch, then
    // encoder count, then stall check on the counted position.
    assign tick_time = ms_time + TIME_BITS'(1);

    always_comb
    begin
        f_drive = flags;
        pos_sw  = pos;
        if (flags.forward)
        begin
            if ((pos_x < goal_x) && (pos_x < limit_x))
            begin
                f_drive.line_minus = 1'b1;
                f_drive.line_plus  = 1'b0;
            end
            else
            begin
                f_drive.reached    = 1'b1;
                f_drive.line_plus  = 1'b0;
                f_drive.line_minus = 1'b0;
                f_drive.active     = 1'b0;
            end
        end
        else
        begin
            if (pos_x > goal_x)
            begin
                if (end_switch)
                begin
                    pos_sw             = '0;
                    f_drive.line_plus  = 1'b0;
                    f_drive.line_minus = 1'b0;
                    f_drive.active     = 1'b0;
                end
                else
                begin
                    f_drive.line_plus  = 1'b1;
                    f_drive.line_minus = 1'b0;
                end
            end
            else
            begin
                f_drive.reached    = 1'b1;
                f_drive.line_plus  = 1'b0;
                f_drive.line_minus = 1'b0;
                f_drive.active     = 1'b0;
            end
        end
    end

    assign enc_step = (encoder_event != ENC_NONE) && (encoder_event != prev_enc);

    always_comb
    begin
        pos_cnt = pos_sw;
        if (enc_step)
        begin
            if (flags.forward)
            begin
                if (pos_sw != POS_MAX)
                    pos_cnt = pos_sw + POSITION_BITS'(1);
            end
            else
            begin
                if (pos_sw != POS_MIN)
                    pos_cnt = pos_sw - POSITION_BITS'(1);
            end
        end
    end

    assign last_tick = enc_step ? tick_time : last_move;
    assign elapsed   = tick_time - last_tick;
    assign stalled   = (elapsed > {{(TIME_BITS-TIMEOUT_W){1'b0}}, stall_timeout_ms})
                       && (prev_pos == pos_cnt);

    always_comb
    begin
        pos_next       = pos;
        goal_next      = goal;
        prev_pos_next  = prev_pos;
        prev_enc_next  = prev_enc;
        ms_time_next   = ms_time;
        last_move_next = last_move;
        flags_next     = flags;

        case (op)
            OP_TICK:
            begin
                ms_time_next = tick_time;
                if (flags.homing)
                begin
                    flags_next.line_plus  = 1'b1;
                    flags_next.line_minus = 1'b0;
                    if (end_switch)
                    begin
                        flags_next.line_plus = 1'b0;
                        flags_next.active    = 1'b0;
                        flags_next.reached   = 1'b1;
                        flags_next.homing    = 1'b0;
                        pos_next             = '0;
                    end
                end
                else if (flags.active)
                begin
                    flags_next     = f_drive;
                    pos_next       = pos_cnt;
                    last_move_next = last_tick;
                    prev_enc_next  = encoder_event;
                    prev_pos_next  = pos_cnt;
                    if (stalled)
                    begin
                        flags_next.blocked    = 1'b1;
                        flags_next.line_plus  = 1'b0;
                        flags_next.line_minus = 1'b0;
                        flags_next.active     = 1'b0;
                    end
                end
            end
            OP_MOVE, OP_RETURN_ZERO:
            begin
                if (do_move)
                begin
                    if (pos_x == want_x)
                    begin
                        flags_next.reached = 1'b1;
                        flags_next.active  = 1'b0;
                    end
                    else
                    begin
                        flags_next.blocked = 1'b0;
                        flags_next.forward = (want_x >= pos_x);
                        flags_next.active  = 1'b1;
                        flags_next.reached = 1'b0;
                        goal_next          = want;
                        last_move_next     = ms_time;
                        prev_pos_next      = pos;
                    end
                end
            end
            OP_HOME:
            begin
                flags_next.homing  = 1'b1;
                flags_next.active  = 1'b1;
                flags_next.forward = 1'b0;
            end
            OP_PAUSE:
            begin
                if (flags.active)
                begin
                    flags_next.line_plus  = 1'b0;
                    flags_next.line_minus = 1'b0;
                end
                flags_next.active = !flags.active;
            end
            OP_STOP:
            begin
                flags_next.line_plus  = 1'b0;
                flags_next.line_minus = 1'b0;
                flags_next.active     = 1'b0;
            end
            default:
            begin
                flags_next = flags;
            end
        endcase
    end

endmodule

// File: design/dc_motor_position_controller_unit.sv
// Latency: the result of a request is valid on the cycle after it is accepted.
// Throughput: one request per cycle while no result waits; state registers
// double as result register, so a request is taken while a result is read out.
// Reset (rst_n low, asynchronous): all axis state cleared, no result pending,
// position limit 100 and stall timeout 1000.
module dc_motor_position_controller_unit #(
    parameter int POSITION_BITS = dmpc_pkg::DMPC_POSITION_BITS,
    parameter int TIME_BITS     = dmpc_pkg::DMPC_TIME_BITS
) (
    input  logic                              clk,
    input  logic                              rst_n,
    dmpc_in_if.sink                           in_ch,
    dmpc_out_if.source                        out_ch,
    input  logic                              cfg_we,
    input  logic [dmpc_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [dmpc_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import dmpc_pkg::*;

    logic [LIMIT_W-1:0]              limit_reg;
    logic [TIMEOUT_W-1:0]            timeout_reg;
    logic signed [POSITION_BITS-1:0] pos_reg,       pos_next;
    logic [LIMIT_W-1:0]              goal_reg,      goal_next;
    logic signed [POSITION_BITS-1:0] prev_pos_reg,  prev_pos_next;
    logic [ENCODER_W-1:0]            prev_enc_reg,  prev_enc_next;
    logic [TIME_BITS-1:0]            ms_time_reg,   ms_time_next;
    logic [TIME_BITS-1:0]            last_move_reg, last_move_next;
    flags_t                          flags_reg,     flags_next;
    logic                            out_valid_reg;
    logic                            in_accept;

    // A request is taken whenever the pending result is gone or leaves now.
    assign in_ch.ready = !out_valid_reg || out_ch.ready;
    assign in_accept   = in_ch.valid && in_ch.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg   <= LIMIT_RESET;
            timeout_reg <= TIMEOUT_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_POSITION_LIMIT: limit_reg   <= cfg_data[LIMIT_W-1:0];
                CFG_STALL_TIMEOUT:  timeout_reg <= cfg_data[TIMEOUT_W-1:0];
                default:            limit_reg   <= limit_reg;
            endcase
        end
    end

    dmpc_step #(
        .POSITION_BITS (POSITION_BITS),
        .TIME_BITS     (TIME_BITS)
    ) u_step (
        .operation        (in_ch.operation),
        .target           (in_ch.target),
        .encoder_event    (in_ch.encoder_event),
        .end_switch       (in_ch.end_switch),
        .position_limit   (limit_reg),
        .stall_timeout_ms (timeout_reg),
        .pos              (pos_reg),
        .goal             (goal_reg),
        .prev_pos         (prev_pos_reg),
        .prev_enc         (prev_enc_reg),
        .ms_time          (ms_time_reg),
        .last_move        (last_move_reg),
        .flags            (flags_reg),
        .pos_next         (pos_next),
        .goal_next        (goal_next),
        .prev_pos_next    (prev_pos_next),
        .prev_enc_next    (prev_enc_next),
        .ms_time_next     (ms_time_next),
        .last_move_next   (last_move_next),
        .flags_next       (flags_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            goal_reg      <= '0;
            prev_pos_reg  <= '0;
            prev_enc_reg  <= ENC_NONE;
            ms_time_reg   <= '0;
            last_move_reg <= '0;
            flags_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_accept)
            begin
                pos_reg       <= pos_next;
                goal_reg      <= goal_next;
                prev_pos_reg  <= prev_pos_next;
                prev_enc_reg  <= prev_enc_next;
                ms_time_reg   <= ms_time_next;
                last_move_reg <= last_move_next;
                flags_reg     <= flags_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_ch.valid          = out_valid_reg;
    assign out_ch.drive_plus     = flags_reg.line_plus;
    assign out_ch.drive_minus    = flags_reg.line_minus;
    assign out_ch.position       = pos_reg;
    assign out_ch.target_reached = flags_reg.reached;
    assign out_ch.blocked        = flags_reg.blocked;
    assign out_ch.moving         = flags_reg.active;
    assign out_ch.homing         = flags_reg.homing;

    // The two drive lines are never energized together.
    assert property (@(posedge clk) disable iff (!rst_n)
        !(flags_reg.line_plus && flags_reg.line_minus))
        else $error("both drive lines active");

    // Every accepted request leaves a result behind.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> out_valid_reg)
        else $error("accepted request produced no result");

    // A fresh stall always leaves the axis stopped.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(flags_reg.blocked) |-> (!flags_reg.active && !flags_reg.line_plus
                                      && !flags_reg.line_minus))
        else $error("axis still driven after stall");

    // The millisecond count moves only on an accepted tick.
    assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(ms_time_reg) |-> $past(in_accept
                                        && (op_t'(in_ch.operation) == OP_TICK)))
        else $error("time count advanced without a tick");

endmodule

// File: dv/dmpc_response_check.sv
`timescale 1ns / 100ps
// Result checker for the motor position controller. It tracks the axis from the
// accepted requests and register writes and compares every result field by field.
// Depends on dmpc_pkg and the channel interfaces of dmpc_if.
module dmpc_response_check #(
    parameter int POSITION_BITS = dmpc_pkg::DMPC_POSITION_BITS
) (
    input  logic                             clk,
    input  logic                             rst_n,
    dmpc_in_if                               req_mon,
    dmpc_out_if                              res_mon,
    input  logic                             cfg_we,
    input  logic [dmpc_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [dmpc_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                             end_of_test,
    output int                               failures
);
    import dmpc_pkg::*;

    localparam int POS_HIGH    = 2 ** (POSITION_BITS - 1) - 1;
    localparam int POS_LOW     = -POS_HIGH - 1;

    typedef struct packed {
        logic                     drive_plus;
        logic                     drive_minus;
        logic [POSITION_BITS-1:0] position;
        logic                     target_reached;
        logic                     blocked;
        logic                     moving;
        logic                     homing;
    } axis_report_t;

    axis_report_t expected_reports[$];

    logic [LIMIT_W-1:0]               limit_cfg;
    logic [TIMEOUT_W-1:0]             timeout_cfg;
    logic signed [POSITION_BITS-1:0]  axis_pos;
    logic signed [POSITION_BITS-1:0]  pos_at_last_tick;
    logic [LIMIT_W-1:0]               goal_pos;
    logic [ENCODER_W-1:0]             last_encoder;
    logic [DMPC_TIME_BITS-1:0]        now_ms;
    logic [DMPC_TIME_BITS-1:0]        moved_ms;
    logic                             active;
    logic                             forward;
    logic                             reached;
    logic                             stalled;
    logic                             homing_on;
    logic                             line_plus;
    logic                             line_minus;
    int                               results_seen;
    bit                               drained;

    task automatic report_mismatch(input string msg);
        failures++;
        $display("%0t check: %s", $realtime, msg);
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("result %0d %s is %0h, predicted %0h",
                                      results_seen, name, got, want));
    endtask

    function automatic void halt_drive();
        line_plus  = 1'b0;
        line_minus = 1'b0;
        active     = 1'b0;
    endfunction

    function automatic void start_move(input int want);
        if (want < 0)
            want = 0;
        if (want > int'(limit_cfg))
            want = int'(limit_cfg);
        if (int'(axis_pos) == want)
        begin
            reached = 1'b1;
            active  = 1'b0;
            return;
        end
        stalled          = 1'b0;
        goal_pos         = LIMIT_W'(want);
        forward          = (want >= int'(axis_pos));
        active           = 1'b1;
        reached          = 1'b0;
        moved_ms         = now_ms;
        pos_at_last_tick = axis_pos;
    endfunction

    function automatic void run_tick(input logic [ENCODER_W-1:0] enc, input logic sw);
        logic [DMPC_TIME_BITS-1:0] elapsed;
        now_ms = now_ms + 1'b1;

        // Homing ignores the encoder and drives backward until the switch closes.
        if (homing_on)
        begin
            line_plus  = 1'b1;
            line_minus = 1'b0;
            if (sw)
            begin
                halt_drive();
                axis_pos  = '0;
                reached   = 1'b1;
                homing_on = 1'b0;
            end
            return;
        end

        if (!active)
            return;

        if (forward)
        begin
            if (int'(axis_pos) < int'(goal_pos) && int'(axis_pos) < int'(limit_cfg))
            begin
                line_minus = 1'b1;
                line_plus  = 1'b0;
            end
            else
            begin
                reached = 1'b1;
                halt_drive();
            end
        end
        else if (int'(axis_pos) > int'(goal_pos))
        begin
            if (sw)
            begin
                axis_pos = '0;
                halt_drive();
            end
            else
            begin
                line_plus  = 1'b1;
                line_minus = 1'b0;
            end
        end
        else
        begin
            reached = 1'b1;
            halt_drive();
        end

        // The encoder is counted even on the tick that stops the axis.
        if (enc != ENC_NONE && enc != last_encoder)
        begin
            if (forward)
            begin
                if (int'(axis_pos) < POS_HIGH)
                    axis_pos = axis_pos + 1'b1;
            end
            else if (int'(axis_pos) > POS_LOW)
                axis_pos = axis_pos - 1'b1;
            moved_ms = now_ms;
        end
        last_encoder = enc;

        elapsed = now_ms - moved_ms;
        if (elapsed > DMPC_TIME_BITS'(timeout_cfg) && pos_at_last_tick == axis_pos)
        begin
            stalled = 1'b1;
            halt_drive();
        end
        pos_at_last_tick = axis_pos;
    endfunction

    function automatic axis_report_t predict_report(input logic [OPERATION_W-1:0] op,
                                                    input logic [TARGET_W-1:0] tgt,
                                                    input logic [ENCODER_W-1:0] enc,
                                                    input logic sw);
        axis_report_t rep;
        case (op)
            OP_TICK:
                run_tick(enc, sw);
            OP_MOVE:
                start_move(int'($signed(tgt)));
            OP_HOME:
            begin
                homing_on = 1'b1;
                active    = 1'b1;
                forward   = 1'b0;
            end
            OP_PAUSE:
            begin
                if (active)
                begin
                    line_plus  = 1'b0;
                    line_minus = 1'b0;
                end
                active = !active;
            end
            OP_STOP:
                halt_drive();
            OP_RETURN_ZERO:
                if (axis_pos != 0)
                    start_move(0);
            default:
                ;
        endcase
        rep.drive_plus     = line_plus;
        rep.drive_minus    = line_minus;
        rep.position       = axis_pos;
        rep.target_reached = reached;
        rep.blocked        = stalled;
        rep.moving         = active;
        rep.homing         = homing_on;
        return rep;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        axis_report_t want;
        if (!rst_n)
        begin
            expected_reports.delete();
            limit_cfg        = LIMIT_RESET;
            timeout_cfg      = TIMEOUT_RESET;
            axis_pos         = '0;
            pos_at_last_tick = '0;
            goal_pos         = '0;
            last_encoder     = ENC_NONE;
            now_ms           = '0;
            moved_ms         = '0;
            active           = 1'b0;
            forward          = 1'b0;
            reached          = 1'b0;
            stalled          = 1'b0;
            homing_on        = 1'b0;
            line_plus        = 1'b0;
            line_minus       = 1'b0;
            results_seen     = 0;
            drained          = 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == CFG_POSITION_LIMIT)
                    limit_cfg = cfg_data[LIMIT_W-1:0];
                else
                    timeout_cfg = cfg_data[TIMEOUT_W-1:0];
            end

            // Results are matched before the new request is predicted, since a
            // result never belongs to the request taken at the same edge.
            if (res_mon.valid && res_mon.ready)
            begin
                if (expected_reports.size() == 0)
                    report_mismatch($sformatf("result %0d arrived with no request pending",
                                              results_seen));
                else
                begin
                    want = expected_reports.pop_front();
                    check_field("drive_plus", res_mon.drive_plus, want.drive_plus);
                    check_field("drive_minus", res_mon.drive_minus, want.drive_minus);
                    check_field("position", res_mon.position, want.position);
                    check_field("target_reached", res_mon.target_reached,
                                want.target_reached);
                    check_field("blocked", res_mon.blocked, want.blocked);
                    check_field("moving", res_mon.moving, want.moving);
                    check_field("homing", res_mon.homing, want.homing);
                end
                results_seen++;
            end

            if (req_mon.valid && req_mon.ready)
                expected_reports.push_back(predict_report(req_mon.operation, req_mon.target,
                                                          req_mon.encoder_event,
                                                          req_mon.end_switch));

            if (end_of_test && !drained)
            begin
                drained = 1'b1;
                if (expected_reports.size() != 0)
                    report_mismatch($sformatf("%0d results never arrived",
                                              expected_reports.size()));
            end
        end
    end

endmodule

// File: dv/dc_motor_position_controller_unit_tb.sv
`timescale 1ns / 100ps
// Top of the motor position controller testbench: clock, reset, request and
// register stimulus, result-side stalls and the verdict. Depends on dmpc_pkg,
// dmpc_if, the controller RTL and dmpc_response_check.
module dc_motor_position_controller_unit_tb;
    import dmpc_pkg::*;

    localparam logic [ENCODER_W-1:0]   ENC_ACTIVATED   = 2'd1;
    localparam logic [ENCODER_W-1:0]   ENC_DEACTIVATED = 2'd2;
    localparam logic [ENCODER_W-1:0]   ENC_OTHER       = 2'd3;
    localparam logic [OPERATION_W-1:0] OP_SPARE_LOW    = 3'd6;
    localparam logic [OPERATION_W-1:0] OP_SPARE_HIGH   = 3'd7;
    localparam int                     RUN_LIMIT_NS    = 6_000_000;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    logic                   end_of_test;
    int                     failures;
    int                     reqs_sent;
    int                     results_taken;
    bit                     no_idle;
    bit                     enc_toggle;
    logic [LIMIT_W-1:0]     cur_limit;

    dmpc_in_if  req_ch ();
    dmpc_out_if res_ch ();

    dc_motor_position_controller_unit u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (req_ch),
        .out_ch    (res_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    dmpc_response_check u_response_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_mon     (req_ch),
        .res_mon     (res_ch),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .end_of_test (end_of_test),
        .failures    (failures)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #(RUN_LIMIT_NS);
        $display("tb: failure");
        $finish;
    end

    // Result side: a fresh stall before every result, none while no_idle is set.
    initial
    begin
        int stall;
        res_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            stall = no_idle ? 0 : $urandom_range(0, 9);
            if (stall != 0)
            begin
                res_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            res_ch.ready <= 1'b1;
            @(posedge clk);
            while (!(res_ch.valid && res_ch.ready))
                @(posedge clk);
            results_taken++;
        end
    end

    task automatic send_req(input logic [OPERATION_W-1:0] op, input logic [TARGET_W-1:0] tgt,
                            input logic [ENCODER_W-1:0] enc, input logic sw);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 9);
        if (gap != 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid         <= 1'b1;
        req_ch.operation     <= op;
        req_ch.target        <= tgt;
        req_ch.encoder_event <= enc;
        req_ch.end_switch    <= sw;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        reqs_sent++;
    endtask

    // Commands ignore the encoder, the switch and, except for a move, the target.
    task automatic send_cmd(input logic [OPERATION_W-1:0] op);
        send_req(op, TARGET_W'($urandom), ENCODER_W'($urandom), 1'($urandom));
    endtask

    task automatic send_move(input logic [TARGET_W-1:0] tgt);
        send_req(OP_MOVE, tgt, ENCODER_W'($urandom), 1'($urandom));
    endtask

    task automatic send_tick(input logic [ENCODER_W-1:0] enc, input logic sw);
        send_req(OP_TICK, TARGET_W'($urandom), enc, sw);
    endtask

    function automatic logic [ENCODER_W-1:0] toggle_encoder();
        enc_toggle = !enc_toggle;
        return enc_toggle ? ENC_ACTIVATED : ENC_DEACTIVATED;
    endfunction

    // Mostly fresh encoder edges, with some silent and repeated events mixed in.
    function automatic logic [ENCODER_W-1:0] next_encoder();
        if ($urandom_range(0, 3) == 0)
            return ENCODER_W'($urandom_range(0, 3));
        if ($urandom_range(0, 9) == 0)
            return ENC_OTHER;
        return toggle_encoder();
    endfunction

    task automatic wait_idle();
        req_ch.valid <= 1'b0;
        while (results_taken != reqs_sent)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic set_config(input logic [LIMIT_W-1:0] new_limit,
                              input logic [TIMEOUT_W-1:0] new_timeout);
        wait_idle();
        cfg_we    <= 1'b1;
        cfg_index <= CFG_POSITION_LIMIT;
        cfg_data  <= CFG_DATA_W'(new_limit);
        @(posedge clk);
        cfg_index <= CFG_STALL_TIMEOUT;
        cfg_data  <= new_timeout;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        cur_limit = new_limit;
    endtask

    task automatic random_phase(input int count);
        int stop_at;
        int kind;
        int r;
        stop_at = reqs_sent + count;
        while (reqs_sent < stop_at)
        begin
            no_idle = ($urandom_range(0, 4) == 0);
            kind    = $urandom_range(0, 9);
            if (kind <= 4 || kind == 7)
            begin
                if (kind == 7)
                    send_cmd(OP_RETURN_ZERO);
                else if ($urandom_range(0, 4) == 0)
                    send_move(TARGET_W'($urandom));
                else
                    send_move(TARGET_W'($urandom_range(0, int'(cur_limit))));
                repeat ($urandom_range(1, 24))
                begin
                    r = $urandom_range(0, 19);
                    if (r == 0)
                        send_cmd(OP_PAUSE);
                    else if (r == 1)
                        send_cmd(OP_STOP);
                    else
                        send_tick(next_encoder(), $urandom_range(0, 11) == 0);
                end
            end
            else if (kind <= 6)
            begin
                send_cmd(OP_HOME);
                repeat ($urandom_range(0, 6))
                begin
                    r = $urandom_range(0, 11);
                    if (r == 0)
                        send_cmd(OP_STOP);
                    else if (r == 1)
                        send_cmd(OP_PAUSE);
                    else
                        send_tick(next_encoder(), 1'b0);
                end
                send_tick(next_encoder(), 1'b1);
            end
            else
            begin
                repeat ($urandom_range(1, 5))
                    send_req(OPERATION_W'($urandom_range(0, 7)), TARGET_W'($urandom),
                             ENCODER_W'($urandom_range(0, 3)), 1'($urandom));
            end
        end
    endtask

    initial
    begin
        rst_n                = 1'b0;
        cfg_we               = 1'b0;
        cfg_index            = CFG_POSITION_LIMIT;
        cfg_data             = '0;
        req_ch.valid         = 1'b0;
        req_ch.operation     = OP_TICK;
        req_ch.target        = '0;
        req_ch.encoder_event = ENC_NONE;
        req_ch.end_switch    = 1'b0;
        end_of_test          = 1'b0;
        no_idle              = 1'b0;
        enc_toggle           = 1'b0;
        cur_limit            = LIMIT_RESET;
        reqs_sent            = 0;
        results_taken        = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed requests under the reset configuration.
        send_tick(ENC_ACTIVATED, 1'b0);
        send_req(OP_SPARE_LOW, TARGET_W'(1023), ENC_OTHER, 1'b1);
        send_req(OP_SPARE_HIGH, TARGET_W'(-1024), ENC_NONE, 1'b0);
        send_move(TARGET_W'(1023));
        send_tick(ENC_ACTIVATED, 1'b0);
        send_tick(ENC_ACTIVATED, 1'b0);
        send_tick(ENC_DEACTIVATED, 1'b0);
        send_tick(ENC_OTHER, 1'b0);
        send_cmd(OP_PAUSE);
        send_cmd(OP_PAUSE);
        send_cmd(OP_STOP);
        send_move(TARGET_W'(-1024));
        send_tick(ENC_DEACTIVATED, 1'b0);
        // End switch closes while the axis is reversing toward its goal.
        send_tick(ENC_ACTIVATED, 1'b1);
        send_cmd(OP_RETURN_ZERO);
        send_tick(ENC_DEACTIVATED, 1'b0);
        send_move('0);
        send_cmd(OP_RETURN_ZERO);
        // Stop idles the lines during homing and pause toggles moving, but homing carries on.
        send_cmd(OP_HOME);
        send_tick(ENC_ACTIVATED, 1'b0);
        send_cmd(OP_STOP);
        send_tick(ENC_NONE, 1'b0);
        send_cmd(OP_PAUSE);
        send_tick(ENC_DEACTIVATED, 1'b1);

        set_config(LIMIT_W'(1023), TIMEOUT_W'(1));
        random_phase(160);
        set_config(LIMIT_W'(0), TIMEOUT_W'(65535));
        random_phase(160);
        set_config(LIMIT_W'(37), TIMEOUT_W'(3));
        random_phase(160);
        set_config(LIMIT_W'(500), TIMEOUT_W'(12));
        random_phase(160);
        set_config(LIMIT_W'($urandom_range(0, 1023)), TIMEOUT_W'($urandom_range(1, 40)));
        random_phase(160);

        wait_idle();
        end_of_test <= 1'b1;
        repeat (2) @(posedge clk);
        if (failures == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
